>>> hw/rtl/assert_macros.svh
// ---------------------------------------------------------------------------
// Assertion macros
// Concurrent assertion helpers for the sunrise sequencer; empty in synthesis.
// ---------------------------------------------------------------------------
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH
`ifndef SYNTHESIS
`define ASSERT_IMPLY(label, clk, rst, ante, cons) \
   label: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) \
      else $error("same-cycle check failed");
`define ASSERT_NEXT(label, clk, rst, ante, cons) \
   label: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) \
      else $error("next-cycle check failed");
`else
`define ASSERT_IMPLY(label, clk, rst, ante, cons)
`define ASSERT_NEXT(label, clk, rst, ante, cons)
`endif
`endif

>>> hw/rtl/salseq_pkg.sv
// ---------------------------------------------------------------------------
// Sunrise sequencer package
// Word types, register map, command and action codes and timing constants.
// ---------------------------------------------------------------------------
package salseq_pkg;

   localparam int CSR_ADDR_W = 5;
   localparam int CSR_DATA_W = 64;

   localparam logic [1:0] REG_DEFAULT_BRIGHTNESS = 2'd0;
   localparam logic [1:0] REG_ALARM_ENABLE       = 2'd1;
   localparam logic [1:0] REG_ALARM_DAYS0_3      = 2'd2;
   localparam logic [1:0] REG_ALARM_DAYS4_6      = 2'd3;

   localparam logic [7:0]  RST_DEFAULT_BRIGHTNESS = 8'd128;
   localparam logic        RST_ALARM_ENABLE       = 1'b0;
   localparam logic [43:0] RST_ALARM_DAYS0_3      = 44'd4125182853480;
   localparam logic [32:0] RST_ALARM_DAYS4_6      = 33'd2517811680;

   localparam logic [1:0] CMD_TICK    = 2'd0;
   localparam logic [1:0] CMD_ENABLE  = 2'd1;
   localparam logic [1:0] CMD_SUNRISE = 2'd2;
   localparam logic [1:0] CMD_TEST    = 2'd3;

   localparam logic [1:0] ACT_NONE  = 2'd0;
   localparam logic [1:0] ACT_SHOW  = 2'd1;
   localparam logic [1:0] ACT_CLEAR = 2'd2;
   localparam logic [1:0] ACT_FRAME = 2'd3;

   localparam logic [31:0] STEP_INTERVAL_MS  = 32'd60000;
   localparam logic [31:0] FRAME_INTERVAL_MS = 32'd50;
   localparam logic [11:0] MINUTES_PER_DAY   = 12'd1440;
   localparam logic [11:0] SUNRISE_LEAD_MIN  = 12'd30;
   localparam logic [11:0] ALARM_OFFSET      = MINUTES_PER_DAY - SUNRISE_LEAD_MIN;

   // Reciprocal of the sunrise divisor (30) scaled by 2^15.
   localparam logic [10:0] SUNRISE_RECIP     = 11'd1093;
   localparam int          SUNRISE_RECIP_SH  = 15;

   localparam int DIV_NUM_W = 24;
   localparam int DIV_DEN_W = 16;
   localparam int DIV_CNT_W = 5;

   typedef struct packed {
      logic [1:0]  command;
      logic [31:0] now_ms;
      logic        enable_value;
      logic [7:0]  target_brightness;
      logic [15:0] duration_ms;
      logic        time_valid;
      logic [2:0]  weekday;
      logic [10:0] minute_of_day;
      logic [8:0]  day_of_year;
   } req_word_type;

   typedef struct packed {
      logic [1:0] action;
      logic [7:0] level;
      logic       last;
      logic       light_on;
      logic       sunrise_running;
      logic       test_running;
   } rsp_word_type;

   typedef struct packed {
      logic [7:0]  default_brightness;
      logic        alarm_enable;
      logic [43:0] alarm_minutes_days0_3;
      logic [32:0] alarm_minutes_days4_6;
   } cfg_type;

   typedef struct packed {
      logic load_item;
      logic div_start;
      logic commit;
   } ctrl_cmd_type;

   typedef struct packed {
      logic div_needed;
      logic div_done;
      logic buf_empty;
   } dp_status_type;

   // Sunrise increment max(1, goal / 30) by reciprocal multiplication.
   function automatic logic [3:0] sunrise_inc(input logic [7:0] goal);
      logic [18:0] prod;
      logic [3:0]  quo;
      prod = 19'(goal) * 19'(SUNRISE_RECIP);
      quo  = prod[SUNRISE_RECIP_SH +: 4];
      return (quo == 4'd0) ? 4'd1 : quo;
   endfunction

endpackage

>>> hw/rtl/sunrise_alarm_light_sequencer_top.sv
// ---------------------------------------------------------------------------
// Sunrise alarm light sequencer, top level
// A word is committed after the capture and calc states, plus a bit-serial divide for
// a test ramp step; the next word is taken only once the controller is back in idle.
// A commit also waits until earlier result words have drained from the buffer.
// Reset is synchronous; lamp state and registers return to defaults at once.
// ---------------------------------------------------------------------------
`include "assert_macros.svh"

module sunrise_alarm_light_sequencer_top
   import salseq_pkg::*;
(
   input  logic                  clock,
   input  logic                  reset,
   input  logic                  req_valid,
   output logic                  req_ready,
   input  req_word_type          req_data,
   output logic                  rsp_valid,
   input  logic                  rsp_ready,
   output rsp_word_type          rsp_data,
   input  logic                  csr_psel,
   input  logic                  csr_penable,
   input  logic                  csr_pwrite,
   input  logic [CSR_ADDR_W-1:0] csr_paddr,
   input  logic [CSR_DATA_W-1:0] csr_pwdata,
   output logic [CSR_DATA_W-1:0] csr_prdata,
   output logic                  csr_pready
);

   cfg_type       cfg_ff;
   ctrl_cmd_type  ctrl_cmd;
   dp_status_type dp_status;
   logic          csr_wr;
   logic [1:0]    reg_idx;
   logic          rsp_ramp_on;
   logic          rsp_is_clear;

   assign csr_pready = 1'b1;
   assign csr_wr     = csr_psel && csr_penable && csr_pwrite;
   assign reg_idx    = csr_paddr[CSR_ADDR_W-1:3];

   always_ff @(posedge clock) begin
      if (reset) begin
         cfg_ff.default_brightness    <= RST_DEFAULT_BRIGHTNESS;
         cfg_ff.alarm_enable          <= RST_ALARM_ENABLE;
         cfg_ff.alarm_minutes_days0_3 <= RST_ALARM_DAYS0_3;
         cfg_ff.alarm_minutes_days4_6 <= RST_ALARM_DAYS4_6;
      end else if (csr_wr) begin
         unique case (reg_idx)
            REG_DEFAULT_BRIGHTNESS: cfg_ff.default_brightness    <= csr_pwdata[7:0];
            REG_ALARM_ENABLE:       cfg_ff.alarm_enable          <= csr_pwdata[0];
            REG_ALARM_DAYS0_3:      cfg_ff.alarm_minutes_days0_3 <= csr_pwdata[43:0];
            REG_ALARM_DAYS4_6:      cfg_ff.alarm_minutes_days4_6 <= csr_pwdata[32:0];
            default: cfg_ff.alarm_enable <= cfg_ff.alarm_enable;
         endcase
      end
   end

   always_comb begin
      unique case (reg_idx)
         REG_DEFAULT_BRIGHTNESS: csr_prdata = CSR_DATA_W'(cfg_ff.default_brightness);
         REG_ALARM_ENABLE:       csr_prdata = CSR_DATA_W'(cfg_ff.alarm_enable);
         REG_ALARM_DAYS0_3:      csr_prdata = CSR_DATA_W'(cfg_ff.alarm_minutes_days0_3);
         REG_ALARM_DAYS4_6:      csr_prdata = CSR_DATA_W'(cfg_ff.alarm_minutes_days4_6);
         default:                csr_prdata = '0;
      endcase
   end

   salseq_ctrl u_ctrl (
      .clock     (clock),
      .reset     (reset),
      .req_valid (req_valid),
      .req_ready (req_ready),
      .status    (dp_status),
      .cmd       (ctrl_cmd)
   );

   salseq_dp u_dp (
      .clock     (clock),
      .reset     (reset),
      .req_data  (req_data),
      .cfg       (cfg_ff),
      .cmd       (ctrl_cmd),
      .status    (dp_status),
      .rsp_valid (rsp_valid),
      .rsp_ready (rsp_ready),
      .rsp_data  (rsp_data)
   );

   assign rsp_ramp_on  = rsp_data.sunrise_running || rsp_data.test_running;
   assign rsp_is_clear = (rsp_data.action == ACT_CLEAR);

   `ASSERT_NEXT(a_one_word_at_a_time, clock, reset, req_valid && req_ready, !req_ready)
   `ASSERT_IMPLY(a_commit_into_empty, clock, reset, ctrl_cmd.commit, dp_status.buf_empty)
   `ASSERT_IMPLY(a_ramp_needs_light, clock, reset, rsp_valid && rsp_ramp_on, rsp_data.light_on)
   `ASSERT_IMPLY(a_clear_when_off, clock, reset, rsp_valid && rsp_is_clear, !rsp_data.light_on)

endmodule

>>> hw/rtl/salseq_div.sv
// ---------------------------------------------------------------------------
// Sunrise sequencer divider
// Restoring divider that retires one quotient bit per cycle.
// ---------------------------------------------------------------------------
module salseq_div
   import salseq_pkg::*;
(
   input  logic                 clock,
   input  logic                 reset,
   input  logic                 start,
   input  logic [DIV_NUM_W-1:0] dividend,
   input  logic [DIV_DEN_W-1:0] divisor,
   output logic [DIV_NUM_W-1:0] quotient,
   output logic                 done
);

   logic [DIV_NUM_W-1:0] quo_ff, quo_in;
   logic [DIV_DEN_W-1:0] rem_ff, rem_in;
   logic [DIV_DEN_W-1:0] den_ff;
   logic [DIV_CNT_W-1:0] cnt_ff, cnt_in;
   logic                 busy_ff, busy_in;
   logic                 done_ff, done_in;
   logic [DIV_DEN_W:0]   rem_sh;
   logic [DIV_DEN_W:0]   diff;
   logic                 fits;

   always_comb begin
      rem_sh  = {rem_ff, quo_ff[DIV_NUM_W-1]};
      diff    = rem_sh - {1'b0, den_ff};
      fits    = rem_sh >= {1'b0, den_ff};
      quo_in  = quo_ff;
      rem_in  = rem_ff;
      cnt_in  = cnt_ff;
      busy_in = busy_ff;
      done_in = 1'b0;
      if (start) begin
         quo_in  = dividend;
         rem_in  = '0;
         cnt_in  = DIV_CNT_W'(DIV_NUM_W);
         busy_in = 1'b1;
      end else if (busy_ff) begin
         quo_in = {quo_ff[DIV_NUM_W-2:0], fits};
         rem_in = fits ? diff[DIV_DEN_W-1:0] : rem_sh[DIV_DEN_W-1:0];
         cnt_in = cnt_ff - 1'b1;
         if (cnt_ff == DIV_CNT_W'(1)) begin
            busy_in = 1'b0;
            done_in = 1'b1;
         end
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         busy_ff <= 1'b0;
         done_ff <= 1'b0;
         cnt_ff  <= '0;
      end else begin
         busy_ff <= busy_in;
         done_ff <= done_in;
         cnt_ff  <= cnt_in;
      end
      quo_ff <= quo_in;
      rem_ff <= rem_in;
      if (start) begin
         den_ff <= divisor;
      end
   end

   assign quotient = quo_ff;
   assign done     = done_ff;

endmodule

>>> hw/rtl/salseq_dp.sv
// ---------------------------------------------------------------------------
// Sunrise sequencer datapath
// Lamp state, ramp arithmetic, alarm match and the two-word result buffer.
// ---------------------------------------------------------------------------
module salseq_dp
   import salseq_pkg::*;
(
   input  logic          clock,
   input  logic          reset,
   input  req_word_type  req_data,
   input  cfg_type       cfg,
   input  ctrl_cmd_type  cmd,
   output dp_status_type status,
   output logic          rsp_valid,
   input  logic          rsp_ready,
   output rsp_word_type  rsp_data
);

   req_word_type item_ff;

   logic        light_ff, light_in;
   logic        cleared_ff, cleared_in;
   logic        sun_on_ff, sun_on_in;
   logic [7:0]  sun_goal_ff, sun_goal_in;
   logic [7:0]  sun_level_ff, sun_level_in;
   logic [31:0] sun_step_ff, sun_step_in;
   logic        day_seen_ff, day_seen_in;
   logic [8:0]  last_day_ff, last_day_in;
   logic        test_on_ff, test_on_in;
   logic [7:0]  test_goal_ff, test_goal_in;
   logic [31:0] test_start_ff, test_start_in;
   logic [15:0] test_len_ff, test_len_in;
   logic [31:0] frame_ff, frame_in;

   rsp_word_type ent0_ff, ent0_in;
   rsp_word_type ent1_ff, ent1_in;
   logic [1:0]   cnt_ff;

   logic [31:0]          elapsed;
   logic [15:0]          len_eff;
   logic                 test_done;
   logic [DIV_NUM_W-1:0] quotient;
   logic [DIV_NUM_W-1:0] dividend;
   logic [10:0]          alarm_min;
   logic                 alarm_day_ok;
   logic [11:0]          start_sum;
   logic [10:0]          start_min;
   logic                 alarm_fire;
   logic                 step_due;
   logic [3:0]           inc;
   logic [8:0]           level_sum;
   logic [7:0]           level_next;
   logic                 pop;

   logic [1:0] res_n;
   logic [1:0] r0_act, r1_act;
   logic [7:0] r0_lvl, r1_lvl;

   always_comb begin
      elapsed   = item_ff.now_ms - test_start_ff;
      len_eff   = (test_len_ff == 16'd0) ? 16'd1 : test_len_ff;
      test_done = elapsed >= {16'd0, len_eff};
      dividend  = DIV_NUM_W'(test_goal_ff) * DIV_NUM_W'(elapsed[15:0]);
   end

   always_comb begin
      alarm_min    = '0;
      alarm_day_ok = 1'b1;
      unique case (item_ff.weekday)
         3'd0: alarm_min = cfg.alarm_minutes_days0_3[10:0];
         3'd1: alarm_min = cfg.alarm_minutes_days0_3[21:11];
         3'd2: alarm_min = cfg.alarm_minutes_days0_3[32:22];
         3'd3: alarm_min = cfg.alarm_minutes_days0_3[43:33];
         3'd4: alarm_min = cfg.alarm_minutes_days4_6[10:0];
         3'd5: alarm_min = cfg.alarm_minutes_days4_6[21:11];
         3'd6: alarm_min = cfg.alarm_minutes_days4_6[32:22];
         default: alarm_day_ok = 1'b0;
      endcase
      start_sum = 12'(alarm_min) + ALARM_OFFSET;
      priority if (start_sum >= 12'(2 * MINUTES_PER_DAY)) begin
         start_min = 11'(start_sum - 12'(2 * MINUTES_PER_DAY));
      end else if (start_sum >= MINUTES_PER_DAY) begin
         start_min = 11'(start_sum - MINUTES_PER_DAY);
      end else begin
         start_min = start_sum[10:0];
      end
      alarm_fire = !test_on_ff && !sun_on_ff && cfg.alarm_enable && item_ff.time_valid
                   && alarm_day_ok && (item_ff.minute_of_day == start_min)
                   && (!day_seen_ff || (last_day_ff != item_ff.day_of_year));
      step_due   = (item_ff.now_ms - sun_step_ff) >= STEP_INTERVAL_MS;
      inc        = sunrise_inc(sun_goal_ff);
      level_sum  = {1'b0, sun_level_ff} + 9'(inc);
      level_next = (level_sum > {1'b0, sun_goal_ff}) ? sun_goal_ff : level_sum[7:0];
   end

   always_comb begin
      light_in      = light_ff;
      cleared_in    = cleared_ff;
      sun_on_in     = sun_on_ff;
      sun_goal_in   = sun_goal_ff;
      sun_level_in  = sun_level_ff;
      sun_step_in   = sun_step_ff;
      day_seen_in   = day_seen_ff;
      last_day_in   = last_day_ff;
      test_on_in    = test_on_ff;
      test_goal_in  = test_goal_ff;
      test_start_in = test_start_ff;
      test_len_in   = test_len_ff;
      frame_in      = frame_ff;
      res_n         = 2'd0;
      r0_act        = ACT_NONE;
      r0_lvl        = '0;
      r1_act        = ACT_NONE;
      r1_lvl        = '0;
      unique case (item_ff.command)
         CMD_TICK: begin
            if (test_on_ff) begin
               res_n  = 2'd1;
               r0_act = ACT_SHOW;
               if (test_done) begin
                  test_on_in = 1'b0;
                  r0_lvl     = test_goal_ff;
               end else begin
                  r0_lvl = quotient[7:0];
               end
            end else if (alarm_fire) begin
               day_seen_in  = 1'b1;
               last_day_in  = item_ff.day_of_year;
               light_in     = 1'b1;
               cleared_in   = 1'b0;
               sun_on_in    = 1'b1;
               sun_goal_in  = cfg.default_brightness;
               sun_level_in = '0;
               sun_step_in  = item_ff.now_ms;
               res_n        = 2'd2;
               r0_act       = ACT_SHOW;
               r0_lvl       = cfg.default_brightness;
               r1_act       = ACT_SHOW;
            end else if (sun_on_ff) begin
               if (step_due) begin
                  sun_step_in  = item_ff.now_ms;
                  sun_level_in = level_next;
                  res_n        = 2'd1;
                  r0_act       = ACT_SHOW;
                  r0_lvl       = level_next;
                  if (level_next >= sun_goal_ff) begin
                     sun_on_in = 1'b0;
                     light_in  = 1'b1;
                  end
               end
            end else if (!light_ff) begin
               if (!cleared_ff) begin
                  cleared_in = 1'b1;
                  res_n      = 2'd1;
                  r0_act     = ACT_CLEAR;
               end
            end else begin
               cleared_in = 1'b0;
               if ((item_ff.now_ms - frame_ff) >= FRAME_INTERVAL_MS) begin
                  frame_in = item_ff.now_ms;
                  res_n    = 2'd1;
                  r0_act   = ACT_FRAME;
                  r0_lvl   = cfg.default_brightness;
               end
            end
         end
         CMD_ENABLE: begin
            light_in = item_ff.enable_value;
            if (item_ff.enable_value) begin
               cleared_in = 1'b0;
               res_n      = 2'd1;
               r0_act     = ACT_SHOW;
               r0_lvl     = cfg.default_brightness;
            end else begin
               sun_on_in  = 1'b0;
               test_on_in = 1'b0;
               cleared_in = 1'b1;
               if (!cleared_ff) begin
                  res_n  = 2'd1;
                  r0_act = ACT_CLEAR;
               end
            end
         end
         CMD_SUNRISE: begin
            light_in     = 1'b1;
            cleared_in   = 1'b0;
            sun_on_in    = 1'b1;
            sun_goal_in  = item_ff.target_brightness;
            sun_level_in = '0;
            sun_step_in  = item_ff.now_ms;
            res_n        = 2'd2;
            r0_act       = ACT_SHOW;
            r0_lvl       = cfg.default_brightness;
            r1_act       = ACT_SHOW;
         end
         CMD_TEST: begin
            light_in      = 1'b1;
            cleared_in    = 1'b0;
            test_on_in    = 1'b1;
            test_goal_in  = item_ff.target_brightness;
            test_start_in = item_ff.now_ms;
            test_len_in   = (item_ff.duration_ms == 16'd0) ? 16'd1 : item_ff.duration_ms;
            res_n         = 2'd1;
            r0_act        = ACT_SHOW;
            r0_lvl        = cfg.default_brightness;
         end
         default: res_n = 2'd0;
      endcase

      ent0_in.action          = r0_act;
      ent0_in.level           = r0_lvl;
      ent0_in.last            = (res_n == 2'd1);
      ent0_in.light_on        = light_in;
      ent0_in.sunrise_running = sun_on_in;
      ent0_in.test_running    = test_on_in;
      ent1_in.action          = r1_act;
      ent1_in.level           = r1_lvl;
      ent1_in.last            = 1'b1;
      ent1_in.light_on        = light_in;
      ent1_in.sunrise_running = sun_on_in;
      ent1_in.test_running    = test_on_in;
   end

   salseq_div u_div (
      .clock    (clock),
      .reset    (reset),
      .start    (cmd.div_start),
      .dividend (dividend),
      .divisor  (len_eff),
      .quotient (quotient),
      .done     (status.div_done)
   );

   always_ff @(posedge clock) begin
      if (cmd.load_item) begin
         item_ff <= req_data;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         light_ff      <= 1'b1;
         cleared_ff    <= 1'b0;
         sun_on_ff     <= 1'b0;
         sun_goal_ff   <= '0;
         sun_level_ff  <= '0;
         sun_step_ff   <= '0;
         day_seen_ff   <= 1'b0;
         last_day_ff   <= '0;
         test_on_ff    <= 1'b0;
         test_goal_ff  <= '0;
         test_start_ff <= '0;
         test_len_ff   <= '0;
         frame_ff      <= '0;
      end else if (cmd.commit) begin
         light_ff      <= light_in;
         cleared_ff    <= cleared_in;
         sun_on_ff     <= sun_on_in;
         sun_goal_ff   <= sun_goal_in;
         sun_level_ff  <= sun_level_in;
         sun_step_ff   <= sun_step_in;
         day_seen_ff   <= day_seen_in;
         last_day_ff   <= last_day_in;
         test_on_ff    <= test_on_in;
         test_goal_ff  <= test_goal_in;
         test_start_ff <= test_start_in;
         test_len_ff   <= test_len_in;
         frame_ff      <= frame_in;
      end
   end

   assign pop = rsp_valid && rsp_ready;

   always_ff @(posedge clock) begin
      if (reset) begin
         cnt_ff <= 2'd0;
      end else if (cmd.commit) begin
         cnt_ff <= res_n;
      end else if (pop) begin
         cnt_ff <= cnt_ff - 2'd1;
      end
   end

   always_ff @(posedge clock) begin
      if (cmd.commit) begin
         ent0_ff <= ent0_in;
         ent1_ff <= ent1_in;
      end else if (pop) begin
         ent0_ff <= ent1_ff;
      end
   end

   assign status.div_needed = (item_ff.command == CMD_TICK) && test_on_ff && !test_done;
   assign status.buf_empty  = (cnt_ff == 2'd0);
   assign rsp_valid         = (cnt_ff != 2'd0);
   assign rsp_data          = ent0_ff;

endmodule

>>> hw/rtl/salseq_ctrl.sv
// ---------------------------------------------------------------------------
// Sunrise sequencer controller
// Steps each word through capture, optional divide and commit.
// ---------------------------------------------------------------------------
module salseq_ctrl
   import salseq_pkg::*;
(
   input  logic          clock,
   input  logic          reset,
   input  logic          req_valid,
   output logic          req_ready,
   input  dp_status_type status,
   output ctrl_cmd_type  cmd
);

   typedef enum logic [3:0] {
      ST_IDLE  = 4'b0001,
      ST_CALC  = 4'b0010,
      ST_DIV   = 4'b0100,
      ST_WRITE = 4'b1000
   } ctrl_state_type;

   ctrl_state_type state_ff, state_in;

   always_comb begin
      state_in      = state_ff;
      req_ready     = 1'b0;
      cmd.load_item = 1'b0;
      cmd.div_start = 1'b0;
      cmd.commit    = 1'b0;
      unique case (state_ff)
         ST_IDLE: begin
            req_ready     = 1'b1;
            cmd.load_item = req_valid;
            if (req_valid) begin
               state_in = ST_CALC;
            end
         end
         ST_CALC: begin
            cmd.div_start = status.div_needed;
            state_in      = status.div_needed ? ST_DIV : ST_WRITE;
         end
         ST_DIV: begin
            if (status.div_done) begin
               state_in = ST_WRITE;
            end
         end
         ST_WRITE: begin
            cmd.commit = status.buf_empty;
            if (status.buf_empty) begin
               state_in = ST_IDLE;
            end
         end
         default: state_in = ST_IDLE;
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff <= ST_IDLE;
      end else begin
         state_ff <= state_in;
      end
   end

endmodule
